FILE: rtl/rtt_pkg.sv
// Package for the request tracker: constants, codes and shared types.
// No dependencies.
package rtt_pkg;
    localparam int MaxPending = 32;
    localparam int NumSeq = 256;
    localparam logic [15:0] TimeoutReset = 16'd1000;

    typedef enum logic [2:0] {
        F_SEND = 3'd0, F_FRAME = 3'd1, F_CANCEL = 3'd2, F_CLEAR = 3'd3, F_TICK = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        K_SENT = 3'd0, K_EXHAUSTED = 3'd1, K_RETRANSMIT = 3'd2, K_TIMEOUT = 3'd3,
        K_DISCONNECT = 3'd4, K_REPLY = 3'd5, K_EVENT = 3'd6, K_CLEARED = 3'd7
    } t_kind;

    typedef struct packed {
        logic        valid;
        logic [7:0]  command;
        logic        retry;
        logic [15:0] deadline;
        logic [15:0] age;
    } t_entry;
endpackage

FILE: rtl/rtt_table.sv
// Entry table: 256 entries in memory plus flip-flop valid bits.
// Depends on rtt_pkg.
module rtt_table import rtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_raddr,
    output t_entry      o_rdata,
    input  logic        i_we,
    input  logic [7:0]  i_waddr,
    input  t_entry      i_wdata,
    input  logic        i_clr_all
);
    logic [40:0] r_mem [NumSeq];
    logic [NumSeq-1:0] r_valid;
    logic [40:0] r_rd;
    logic r_rv;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata[40:0];
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rv <= 1'b0;
        end else begin
            r_rv <= r_valid[i_raddr];
            if (i_clr_all) r_valid <= '0;
            else if (i_we) r_valid[i_waddr] <= i_wdata.valid;
        end
    end

    assign o_rdata = {r_rv, r_rd};
endmodule

FILE: rtl/request_tracker_timeout_retry.sv
// Top level of the request tracker: handshakes, sequencer and result register.
// Depends on rtt_pkg and rtt_table.
//
//  port group   dir  payload (low bit first)
//  s_axis       in   tdata: func[2:0] command[10:3] sequence_req[18:11]; tuser: is_event,
//                    is_response, is_error
//  m_axis       out  tdata: kind[2:0] seq_out[10:3] command_out[18:11] latency[34:19];
//                    tuser: error_reply; tlast: last
//  cfg          in   timeout_ticks, 16 bits
//
// Steps: accept, then read and evaluate each table entry visited, then finish.
// Send probes from next_sequence until a free entry; exhausted at the pending limit skips
// the table, and a frame visits one entry. Cancel and clear walk all 256 entries; a tick
// walks twice, first aging and retrying, then failing expired entries. Unused func codes are accepted and ignored.
// A new result waits while the previous one is unread; the input waits for an empty output.
// Reset is synchronous and clears the valid bits at once.
module request_tracker_timeout_retry import rtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // func, command, sequence_req, pad
    input  logic [2:0]  s_axis_tuser,   // is_event, is_response, is_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // kind, seq_out, command_out, latency, pad
    output logic        m_axis_tuser,   // error_reply
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_READ = 5'b00010, S_EVAL = 5'b00100,
        S_OUT = 5'b01000, S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_tmo;
    logic [2:0]  r_func;
    logic [7:0]  r_cmd, r_seq;
    logic [2:0]  r_flags;
    logic [8:0]  r_idx, n_idx;      // walk counter over the table
    logic        r_pass, n_pass;    // tick: 0 retry pass, 1 fail pass
    logic [7:0]  r_nseq, n_nseq;
    logic [8:0]  r_pend, n_pend;
    // held result
    logic        r_hv, n_hv;
    logic [34:0] r_hd, n_hd;
    logic        r_he, n_he;
    logic        r_ov, n_ov;
    logic [34:0] r_od, n_od;
    logic        r_oe, n_oe, r_ol, n_ol;

    t_entry rd, wd;
    logic we, clr, gen;
    logic [7:0] addr;
    logic [15:0] eff_tmo;
    logic [15:0] age1, dl1;

    assign eff_tmo = (r_tmo == 16'd0) ? 16'd1 : r_tmo;
    assign addr = (r_func == F_SEND) ? r_nseq + r_idx[7:0]
                : (r_func == F_FRAME) ? r_seq : r_idx[7:0];

    rtt_table u_table (.i_clk, .i_rst_n, .i_raddr(addr), .o_rdata(rd), .i_we(we),
                       .i_waddr(addr), .i_wdata(wd), .i_clr_all(clr));

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign cfg_ready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {5'd0, r_od};
    assign m_axis_tuser = r_oe;
    assign m_axis_tlast = r_ol;

    always_comb begin
        age1 = (rd.age == 16'hFFFF) ? rd.age : rd.age + 16'd1;
        dl1  = (rd.deadline == 16'd0) ? 16'd0 : rd.deadline - 16'd1;
    end

    // Flush rule: a held result goes out once the next result of the same request is
    // ready; the one still held when the request completes goes out with the last flag.
    // In the fail pass of a tick, a valid entry with a zero deadline is one that expired
    // without a retry left: a retransmit always reloads a nonzero deadline.
    always_comb begin
        n_state = r_state; n_idx = r_idx; n_pass = r_pass;
        n_nseq = r_nseq; n_pend = r_pend;
        n_hv = r_hv; n_hd = r_hd; n_he = r_he;
        n_ov = r_ov; n_od = r_od; n_oe = r_oe; n_ol = r_ol;
        we = 1'b0; clr = 1'b0; gen = 1'b0; wd = rd;
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_idx = '0; n_pass = 1'b0;
                    n_state = S_READ;
                    if (s_axis_tdata[2:0] == F_CLEAR) begin
                        n_hv = 1'b1; n_hd = {16'd0, 16'd0, K_CLEARED}; n_he = 1'b0;
                    end
                    if (s_axis_tdata[2:0] == F_SEND && r_pend >= 9'(MaxPending)) begin
                        n_hv = 1'b1; n_he = 1'b0;
                        n_hd = {16'd0, s_axis_tdata[10:3], r_nseq, K_EXHAUSTED};
                        n_state = S_DONE;
                    end
                    if (s_axis_tdata[2:0] > F_TICK) n_state = S_IDLE;
                end
            end
            S_READ: n_state = S_EVAL;  // table read latency
            S_EVAL: begin
                // one entry per visit
                n_state = S_READ;
                n_idx = r_idx + 9'd1;
                case (r_func)
                    F_SEND: begin
                        if (!rd.valid) begin
                            we = 1'b1;
                            wd = '{valid: 1'b1, command: r_cmd, retry: 1'b1,
                                   deadline: eff_tmo, age: 16'd0};
                            n_pend = r_pend + 9'd1; n_nseq = addr + 8'd1;
                            gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                            n_hd = {16'd0, r_cmd, addr, K_SENT};
                            n_state = S_DONE;
                        end else if (r_idx == 9'd255) begin
                            gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                            n_hd = {16'd0, r_cmd, r_nseq, K_EXHAUSTED};
                            n_state = S_DONE;
                        end
                    end
                    F_FRAME: begin
                        n_state = S_DONE;
                        if (r_flags[0]) begin
                            gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                            n_hd = {16'd0, r_cmd, r_seq, K_EVENT};
                        end else if ((r_flags[1] | r_flags[2]) && rd.valid
                                     && rd.command == r_cmd) begin
                            we = 1'b1; wd.valid = 1'b0; n_pend = r_pend - 9'd1;
                            gen = 1'b1; n_hv = 1'b1; n_he = r_flags[2];
                            n_hd = {rd.age, r_cmd, r_seq, K_REPLY};
                        end
                    end
                    F_CANCEL: begin
                        if (rd.valid && rd.command == r_cmd) begin
                            we = 1'b1; wd.valid = 1'b0; n_pend = r_pend - 9'd1;
                        end
                    end
                    F_CLEAR: begin
                        if (rd.valid) begin
                            we = 1'b1; wd.valid = 1'b0;
                            gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                            n_hd = {rd.age, rd.command, addr, K_DISCONNECT};
                        end
                    end
                    default: begin  // tick
                        if (!r_pass && rd.valid) begin
                            we = 1'b1; wd.age = age1; wd.deadline = dl1;
                            if (dl1 == 16'd0 && rd.retry) begin
                                wd.retry = 1'b0; wd.deadline = eff_tmo;
                                gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                                n_hd = {16'd0, rd.command, addr, K_RETRANSMIT};
                            end
                        end else if (r_pass && rd.valid && rd.deadline == 16'd0) begin
                            we = 1'b1; wd.valid = 1'b0; n_pend = r_pend - 9'd1;
                            gen = 1'b1; n_hv = 1'b1; n_he = 1'b0;
                            n_hd = {rd.age, rd.command, addr, K_TIMEOUT};
                        end
                    end
                endcase
                if (r_idx == 9'd255 && n_state == S_READ) begin
                    if (r_func == F_TICK && !r_pass) begin
                        n_pass = 1'b1; n_idx = '0;
                    end else n_state = S_DONE;
                end
                // A new result pushes the held one out first; hold this entry while the
                // output register is still busy.
                if (gen && r_hv) begin
                    if (n_ov) begin
                        we = 1'b0; n_state = S_EVAL; n_idx = r_idx; n_pass = r_pass;
                        n_pend = r_pend; n_nseq = r_nseq; n_hd = r_hd; n_he = r_he;
                    end else begin
                        n_ov = 1'b1; n_od = r_hd; n_oe = r_he; n_ol = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (r_func == F_CLEAR) begin
                    clr = 1'b1; n_pend = '0;
                end
                if (!r_hv) n_state = S_IDLE;
                else if (!n_ov) begin
                    n_ov = 1'b1; n_od = r_hd; n_oe = r_he; n_ol = 1'b1; n_hv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_tmo <= TimeoutReset; r_nseq <= '0; r_pend <= '0;
            r_hv <= 1'b0; r_ov <= 1'b0; r_idx <= '0; r_pass <= 1'b0;
        end else begin
            r_state <= n_state; r_nseq <= n_nseq; r_pend <= n_pend; r_hv <= n_hv;
            r_ov <= n_ov; r_idx <= n_idx; r_pass <= n_pass;
            if (cfg_valid && cfg_ready) r_tmo <= cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hd <= n_hd; r_he <= n_he; r_od <= n_od; r_oe <= n_oe; r_ol <= n_ol;
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tdata[2:0]; r_cmd <= s_axis_tdata[10:3];
            r_seq <= s_axis_tdata[18:11]; r_flags <= s_axis_tuser;
        end
    end

    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 9'(MaxPending)) else $error("pending count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov) else $error("result lost");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_hv) else $error("held result at idle");
endmodule

FILE: tb/request_tracker_timeout_retry_tb.sv
// Testbench for request_tracker_timeout_retry: directed table, then random phases,
// all results checked against a behavioral model of the tracker kept in this file.
// Depends on rtt_pkg and the tracker RTL.
module request_tracker_timeout_retry_tb;
    import rtt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused func codes: the block must ignore them.
    localparam logic [2:0] F_UNUSED_LO = 3'd5;
    localparam logic [2:0] F_UNUSED_HI = 3'd7;
    // Longest walk is a tick: two passes over 256 entries, each entry read and then evaluated.
    localparam int WalkCycles = 1200;
    localparam int WatchLimit = 20000;
    localparam int LongHold = 3000;

    typedef struct {
        t_kind       kind;
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [15:0] lat;
        logic        err;
        logic        last;
    } t_result;

    typedef struct {
        logic [2:0] func;
        logic [7:0] cmd;
        logic [7:0] seq;
        logic       ev;
        logic       rsp;
        logic       er;
        bit         typed;     // first result is known by inspection
        t_kind      k;
        logic [7:0] ks;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // func, command, sequence_req, pad
    logic [2:0]  s_axis_tuser = '0;   // is_event, is_response, is_error
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // kind, seq_out, command_out, latency, pad
    logic        m_axis_tuser;        // error_reply
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    request_tracker_timeout_retry dut (.*);

    always #10 i_clk = ~i_clk;

    // Model state of the tracker.
    bit          pend_valid [NumSeq];
    logic [7:0]  pend_cmd [NumSeq];
    bit          pend_retry [NumSeq];
    logic [15:0] pend_deadline [NumSeq];
    logic [15:0] pend_age [NumSeq];
    logic [7:0]  next_seq;
    int          pend_count;
    logic [15:0] timeout_ticks;

    t_result     expected_results[$];
    t_result     item_results[$];
    bit          failed = 0;
    bit          no_idle = 0;
    bit          hold_request = 0;

    function automatic logic [15:0] eff_timeout();
        return (timeout_ticks == 0) ? 16'd1 : timeout_ticks;
    endfunction

    function automatic void add_result(t_kind k, logic [7:0] s, logic [7:0] c,
                                       logic [15:0] l, logic e);
        t_result r;
        r.kind = k; r.seq = s; r.cmd = c; r.lat = l; r.err = e; r.last = 1'b0;
        item_results = {item_results, r};
    endfunction

    function automatic void drop_entry(int s);
        if (pend_valid[s]) begin
            pend_valid[s] = 0;
            if (pend_count > 0) pend_count--;
        end
    endfunction

    // Advance the model by one accepted request; results land in item_results.
    function automatic void track_request(logic [2:0] func, logic [7:0] cmd,
                                          logic [7:0] seq, logic ev, logic rsp,
                                          logic er);
        bit   found;
        bit   fail [NumSeq];
        int   cand;
        item_results.delete();
        case (func)
            F_SEND: begin
                found = 0;
                cand = next_seq;
                if (pend_count < MaxPending) begin
                    for (int i = 0; i < NumSeq && !found; i++) begin
                        cand = (next_seq + i) % NumSeq;
                        if (!pend_valid[cand]) found = 1;
                    end
                end
                if (!found) begin
                    add_result(K_EXHAUSTED, next_seq, cmd, 16'd0, 1'b0);
                end else begin
                    pend_valid[cand] = 1;
                    pend_cmd[cand] = cmd;
                    pend_retry[cand] = 1;
                    pend_deadline[cand] = eff_timeout();
                    pend_age[cand] = '0;
                    pend_count++;
                    next_seq = 8'(cand + 1);
                    add_result(K_SENT, 8'(cand), cmd, 16'd0, 1'b0);
                end
            end
            F_FRAME: begin
                if (ev) begin
                    add_result(K_EVENT, seq, cmd, 16'd0, 1'b0);
                end else if ((rsp || er) && pend_valid[seq] && pend_cmd[seq] == cmd) begin
                    add_result(K_REPLY, seq, cmd, pend_age[seq], er);
                    drop_entry(seq);
                end
            end
            F_CANCEL: begin
                for (int s = 0; s < NumSeq; s++)
                    if (pend_valid[s] && pend_cmd[s] == cmd) drop_entry(s);
            end
            F_CLEAR: begin
                add_result(K_CLEARED, 8'd0, 8'd0, 16'd0, 1'b0);
                for (int s = 0; s < NumSeq; s++) begin
                    if (pend_valid[s]) begin
                        add_result(K_DISCONNECT, 8'(s), pend_cmd[s], pend_age[s], 1'b0);
                        pend_valid[s] = 0;
                    end
                end
                pend_count = 0;
            end
            F_TICK: begin
                // Retransmits first, in ascending order, then the failures.
                for (int s = 0; s < NumSeq; s++) begin
                    fail[s] = 0;
                    if (!pend_valid[s]) continue;
                    if (pend_age[s] != 16'hFFFF) pend_age[s]++;
                    if (pend_deadline[s] > 0) pend_deadline[s]--;
                    if (pend_deadline[s] != 0) continue;
                    if (pend_retry[s]) begin
                        pend_retry[s] = 0;
                        pend_deadline[s] = eff_timeout();
                        add_result(K_RETRANSMIT, 8'(s), pend_cmd[s], 16'd0, 1'b0);
                    end else begin
                        fail[s] = 1;
                    end
                end
                for (int s = 0; s < NumSeq; s++) begin
                    if (fail[s]) begin
                        add_result(K_TIMEOUT, 8'(s), pend_cmd[s], pend_age[s], 1'b0);
                        drop_entry(s);
                    end
                end
            end
            default: ;
        endcase
        if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
        expected_results = {expected_results, item_results};
    endfunction

    // Offer one request, in some cases after a random gap; hold valid high if the next one follows at once.
    task automatic send_request(logic [2:0] func, logic [7:0] cmd, logic [7:0] seq,
                                logic ev, logic rsp, logic er);
        int r;
        r = $urandom_range(0, 99);
        if (!no_idle && r >= 60) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80))
                @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'd0, seq, cmd, func};
        s_axis_tuser = {er, rsp, ev};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_request(func, cmd, seq, ev, rsp, er);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait for every expected result, then let a silent walk finish.
    task automatic drain();
        release_input();
        wait (expected_results.size() == 0);
        repeat (WalkCycles) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        timeout_ticks = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Random mix: mostly sends, ticks and replies that match a pending entry.
    task automatic random_phase(int count);
        int         r;
        int         start;
        logic [7:0] cmd;
        logic [7:0] seq;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            cmd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
            if (r < 30) begin
                send_request(F_SEND, cmd, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end else if (r < 60) begin
                send_request(F_TICK, cmd, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end else if (r < 85) begin
                seq = 8'($urandom);
                if (pend_count > 0 && $urandom_range(0, 3) != 0) begin
                    // Pick a pending entry and reply to it.
                    start = $urandom_range(0, NumSeq - 1);
                    for (int i = 0; i < NumSeq; i++) begin
                        if (pend_valid[(start + i) % NumSeq]) begin
                            seq = 8'((start + i) % NumSeq);
                            break;
                        end
                    end
                    cmd = pend_cmd[seq];
                    r = $urandom_range(1, 3);
                    send_request(F_FRAME, cmd, seq, 1'b0, r[0], r[1]);
                end else begin
                    r = $urandom_range(0, 7);
                    send_request(F_FRAME, cmd, seq, r[0], r[1], r[2]);
                end
            end else if (r < 91) begin
                send_request(F_CANCEL, cmd, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end else if (r < 96) begin
                send_request(F_CLEAR, cmd, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end else begin
                r = $urandom_range(0, 7);
                send_request(3'($urandom_range(F_UNUSED_LO, F_UNUSED_HI)), cmd,
                             8'($urandom), r[0], r[1], r[2]);
            end
        end
    endtask

    // Receiver: random ready with short and long gaps, plus one long hold on request.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (LongHold) @(negedge i_clk);
                hold_request = 0;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: m_axis_tready = 1'b0;
                    5: begin
                        m_axis_tready = 1'b0;
                        repeat ($urandom_range(10, 60)) @(negedge i_clk);
                    end
                    default: m_axis_tready = 1'b1;
                endcase
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d seq=%0d", m_axis_tdata[2:0],
                       m_axis_tdata[10:3]);
                failed = 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[2:0] !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tdata[2:0]);
                    failed = 1;
                end
                if (m_axis_tdata[10:3] !== exp_r.seq) begin
                    $error("seq_out: expected %0d, got %0d", exp_r.seq, m_axis_tdata[10:3]);
                    failed = 1;
                end
                if (m_axis_tdata[18:11] !== exp_r.cmd) begin
                    $error("command_out: expected %0d, got %0d", exp_r.cmd,
                           m_axis_tdata[18:11]);
                    failed = 1;
                end
                if (m_axis_tdata[34:19] !== exp_r.lat) begin
                    $error("latency: expected %0d, got %0d", exp_r.lat, m_axis_tdata[34:19]);
                    failed = 1;
                end
                if (m_axis_tuser !== exp_r.err) begin
                    $error("error_reply: expected %0d, got %0d", exp_r.err, m_axis_tuser);
                    failed = 1;
                end
                if (m_axis_tlast !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_axis_tlast);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    t_row rows [16];

    initial begin
        // Directed rows; typed expectations only where obvious after reset.
        rows[0]  = '{F_SEND,   8'd0,   8'd0,   0, 0, 0, 1, K_SENT,    8'd0};
        rows[1]  = '{F_SEND,   8'd255, 8'd255, 0, 0, 0, 1, K_SENT,    8'd1};
        rows[2]  = '{F_FRAME,  8'd0,   8'd0,   0, 1, 0, 1, K_REPLY,   8'd0};
        rows[3]  = '{F_FRAME,  8'd255, 8'd1,   0, 0, 1, 1, K_REPLY,   8'd1};
        // event wins over response and error flags
        rows[4]  = '{F_FRAME,  8'd255, 8'd255, 1, 1, 1, 1, K_EVENT,   8'd255};
        rows[5]  = '{F_FRAME,  8'd0,   8'd0,   0, 0, 0, 0, K_SENT,    8'd0};
        rows[6]  = '{F_FRAME,  8'd9,   8'd5,   0, 1, 0, 0, K_SENT,    8'd0};
        rows[7]  = '{F_SEND,   8'd7,   8'd0,   0, 0, 0, 1, K_SENT,    8'd2};
        // command mismatch on a valid entry
        rows[8]  = '{F_FRAME,  8'd8,   8'd2,   0, 1, 1, 0, K_SENT,    8'd0};
        rows[9]  = '{F_CANCEL, 8'd7,   8'd0,   0, 0, 0, 0, K_SENT,    8'd0};
        rows[10] = '{3'd5,     8'd1,   8'd1,   1, 1, 1, 0, K_SENT,    8'd0};
        rows[11] = '{3'd7,     8'd2,   8'd2,   1, 0, 1, 0, K_SENT,    8'd0};
        rows[12] = '{F_TICK,   8'd0,   8'd0,   0, 0, 0, 0, K_SENT,    8'd0};
        rows[13] = '{F_SEND,   8'd66,  8'd0,   0, 0, 0, 1, K_SENT,    8'd3};
        rows[14] = '{F_CLEAR,  8'd0,   8'd0,   0, 0, 0, 1, K_CLEARED, 8'd0};
        rows[15] = '{3'd6,     8'd0,   8'd0,   0, 0, 0, 0, K_SENT,    8'd0};

        foreach (pend_valid[s]) pend_valid[s] = 0;
        next_seq = '0;
        pend_count = 0;
        timeout_ticks = TimeoutReset;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            send_request(rows[i].func, rows[i].cmd, rows[i].seq, rows[i].ev, rows[i].rsp,
                         rows[i].er);
            if (rows[i].typed && (item_results.size() == 0 ||
                item_results[0].kind != rows[i].k || item_results[0].seq != rows[i].ks)) begin
                $error("row %0d: expected kind %0d seq %0d", i, rows[i].k, rows[i].ks);
                failed = 1;
            end
        end
        drain();

        // Shortest timeout: retransmit then fail on consecutive ticks.
        write_timeout(16'd1);
        random_phase(25);
        drain();
        write_timeout(16'd0);
        random_phase(20);
        drain();

        // Reach the pending limit with the receiver held off, then overflow it, tick and clear the table.
        write_timeout(16'hFFFF);
        hold_request = 1;
        for (int n = 0; n < MaxPending + 2; n++)
            send_request(F_SEND, 8'($urandom), 8'd0, 1'b0, 1'b0, 1'b0);
        send_request(F_TICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_request(F_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        drain();

        no_idle = 1;
        write_timeout(16'd3);
        random_phase(20);
        drain();
        no_idle = 0;
        write_timeout(16'd2);
        random_phase(20);
        drain();
        write_timeout(TimeoutReset);
        random_phase(15);
        drain();
        write_timeout(16'd5);
        random_phase(20);
        drain();

        if (!failed && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: request_tracker_timeout_retry.f
rtl/rtt_pkg.sv
rtl/rtt_table.sv
rtl/request_tracker_timeout_retry.sv
tb/request_tracker_timeout_retry_tb.sv
